[rtl/otb_pkg.sv]
// Shared types, widths and codes of the Otsu threshold binarizer.
package otb_pkg;

  // Histogram geometry.
  localparam int COUNT_BITS = 20;
  localparam int BINS       = 256;
  localparam int BIN_BITS   = $clog2(BINS);
  localparam int PIX_BITS   = 8;

  // Widths of the search arithmetic, derived from the histogram geometry.
  localparam int N_BITS    = COUNT_BITS + BIN_BITS;  // pixel count of a frame
  localparam int S_BITS    = N_BITS + BIN_BITS;      // intensity sum of a frame
  localparam int P_BITS    = S_BITS + N_BITS;        // cross product s*n
  localparam int NUM_BITS  = 2 * P_BITS;             // squared difference
  localparam int DEN_BITS  = 2 * N_BITS;             // n1*n2
  localparam int CMP_BITS  = NUM_BITS + DEN_BITS;    // cross-multiplied score
  localparam int MB_BITS   = P_BITS;                 // multiplier operand b
  localparam int PROD_BITS = NUM_BITS + MB_BITS;     // multiplier product
  localparam int WP_BITS   = BIN_BITS + COUNT_BITS;  // bin index times count

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [PIX_BITS-1:0]   PIX_MAX   = {PIX_BITS{1'b1}};
  localparam logic [PIX_BITS-1:0]   PIX_MIN   = '0;

  // Command and result codes.
  localparam logic FUNC_ACCUMULATE = 1'b0;
  localparam logic FUNC_BINARIZE   = 1'b1;
  localparam logic KIND_THRESHOLD  = 1'b0;
  localparam logic KIND_PIXEL      = 1'b1;

  // One command beat.
  typedef struct packed {
    logic                func;
    logic [PIX_BITS-1:0] pixel;
    logic                frame_end;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic                result_kind;
    logic [PIX_BITS-1:0] level;
  } res_t;

  // Request to the serial multiplier.
  typedef struct packed {
    logic                go;
    logic [NUM_BITS-1:0] a;
    logic [MB_BITS-1:0]  b;
  } mul_req_t;

  // Status of the serial multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

[rtl/otb_ram.sv]
// Generic simple dual-port RAM with a registered read port.
module otb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/otb_mul.sv]
// Radix-2 shift-and-add multiplier, one bit of operand b per cycle.
module otb_mul
  import otb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  mul_req_t             req,
  output mul_stat_t            stat,
  output logic [PROD_BITS-1:0] product
);

  localparam int CNT_BITS = $clog2(MB_BITS + 1);

  logic [NUM_BITS-1:0]  a_q;
  logic [PROD_BITS-1:0] p;
  logic [CNT_BITS-1:0]  cnt;
  logic                 run;
  logic                 done;
  logic [NUM_BITS:0]    sum;

  // Add a into the upper half when the current multiplier bit is set.
  always_comb begin
    sum = {1'b0, p[PROD_BITS-1:MB_BITS]} + (p[0] ? {1'b0, a_q} : {(NUM_BITS+1){1'b0}});
  end

  // Operand latch and shifting product register.
  always_ff @(posedge clk) begin
    if (req.go) begin
      a_q <= req.a;
      p   <= {{NUM_BITS{1'b0}}, req.b};
    end else if (run) begin
      p <= {sum, p[MB_BITS-1:1]};
    end
  end

  // Step counter and completion strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
        cnt <= CNT_BITS'(MB_BITS);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = run;
  assign stat.done = done;
  assign product   = p;

endmodule

[rtl/otsu_threshold_binarizer_unit.sv]
// Top level of the Otsu threshold binarizer: histogram, threshold search, binarize.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+------------------------------------
//  command  | start, busy, cmd       | beat taken when start && !busy
//  result   | done, res              | beat valid for one cycle when done
//
// Accumulate and binarize beats are taken one per cycle while busy is low; a
// binarized pixel appears on res in the cycle after its command beat. The histogram
// lives in one RAM with a registered read; back-to-back hits on a bin are forwarded.
// A frame-end beat holds busy for the search: a pass over the bins up to the
// brightest bin for the totals, then a pass over the thresholds, scored with the
// shared serial multiplier, then a sweep that zeroes the bins up to the brightest.
// After reset busy stays high while the whole histogram is cleared.
// The receiver cannot stall results.
module otsu_threshold_binarizer_unit
  import otb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t res
);

  typedef enum logic [3:0] {
    S_IDLE, S_DRAIN, S_SUM_RD, S_SUM_ACC, S_SR_RD, S_SR_ACC, S_SR_DIFF,
    S_SR_CHK, S_MUL_GO, S_MUL_WAIT, S_CMP, S_NEXT, S_EMIT, S_CLR
  } state_t;

  typedef enum logic [2:0] {
    OP_SN, OP_NS, OP_SQ, OP_NN, OP_LHS, OP_RHS
  } op_t;

  state_t state;
  op_t    op;

  // Histogram RAM ports.
  logic                  ram_we;
  logic [BIN_BITS-1:0]   ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [BIN_BITS-1:0]   ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  // Accumulate pipeline and write forwarding.
  logic                  accept;
  logic [BIN_BITS-1:0]   pix_idx;
  logic                  acc_vld;
  logic [BIN_BITS-1:0]   acc_idx;
  logic [COUNT_BITS-1:0] acc_cur;
  logic [COUNT_BITS-1:0] acc_new;
  logic                  wr_vld_q;
  logic [BIN_BITS-1:0]   wr_addr_q;
  logic [COUNT_BITS-1:0] wr_data_q;

  // Search state.
  logic [BIN_BITS-1:0]   brightest;
  logic [BIN_BITS-1:0]   chosen_level;
  logic [BIN_BITS-1:0]   bin_idx;
  logic [BIN_BITS-1:0]   clr_last;
  logic [BIN_BITS-1:0]   best;
  logic [N_BITS-1:0]     total_n;
  logic [S_BITS-1:0]     total_s;
  logic [N_BITS-1:0]     n1;
  logic [S_BITS-1:0]     s1;
  logic [N_BITS-1:0]     n2;
  logic [S_BITS-1:0]     s2;
  logic [P_BITS-1:0]     cross_a;
  logic [P_BITS-1:0]     cross_b;
  logic [P_BITS-1:0]     diff;
  logic [NUM_BITS-1:0]   num;
  logic [DEN_BITS-1:0]   den;
  logic [NUM_BITS-1:0]   best_num;
  logic [DEN_BITS-1:0]   best_den;
  logic [CMP_BITS-1:0]   lhs;
  logic [WP_BITS-1:0]    weighted;

  // Multiplier.
  mul_req_t              mul_req;
  mul_stat_t             mul_stat;
  logic [PROD_BITS-1:0]  product;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Pixels beyond the last bin count in the last bin.
  always_comb begin
    if (int'(cmd.pixel) >= BINS) begin
      pix_idx = BIN_BITS'(BINS - 1);
    end else begin
      pix_idx = cmd.pixel[BIN_BITS-1:0];
    end
  end

  // Saturating increment with forwarding of the previous cycle's write.
  always_comb begin
    if (wr_vld_q && (wr_addr_q == acc_idx)) begin
      acc_cur = wr_data_q;
    end else begin
      acc_cur = ram_rdata;
    end
    acc_new = (acc_cur == COUNT_MAX) ? acc_cur : acc_cur + 1'b1;
  end

  // RAM address and write selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = acc_idx;
    ram_wdata = acc_new;
    if (acc_vld) begin
      ram_we = 1'b1;
    end else if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = bin_idx;
      ram_wdata = '0;
    end
    ram_raddr = (state == S_IDLE) ? pix_idx : bin_idx;
  end

  // Bin index times count for the intensity sums.
  assign weighted = WP_BITS'(bin_idx) * WP_BITS'(ram_rdata);

  // Absolute difference of the two cross products.
  assign diff = (cross_a >= cross_b) ? (cross_a - cross_b) : (cross_b - cross_a);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_req.go = (state == S_MUL_GO);
    mul_req.a  = '0;
    mul_req.b  = '0;
    unique case (op)
      OP_SN: begin
        mul_req.a = NUM_BITS'(s1);
        mul_req.b = MB_BITS'(n2);
      end
      OP_NS: begin
        mul_req.a = NUM_BITS'(s2);
        mul_req.b = MB_BITS'(n1);
      end
      OP_SQ: begin
        mul_req.a = NUM_BITS'(diff);
        mul_req.b = diff;
      end
      OP_NN: begin
        mul_req.a = NUM_BITS'(n1);
        mul_req.b = MB_BITS'(n2);
      end
      OP_LHS: begin
        mul_req.a = num;
        mul_req.b = MB_BITS'(best_den);
      end
      OP_RHS: begin
        mul_req.a = best_num;
        mul_req.b = MB_BITS'(den);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  otb_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .stat    (mul_stat),
    .product (product)
  );

  otb_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BINS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Forwarding register: the last write to the histogram.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_vld_q <= 1'b0;
    end else begin
      wr_vld_q <= ram_we;
    end
    wr_addr_q <= ram_waddr;
    wr_data_q <= ram_wdata;
  end

  // Main sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      op           <= OP_SN;
      bin_idx      <= '0;
      clr_last     <= BIN_BITS'(BINS - 1);
      brightest    <= '0;
      chosen_level <= BIN_BITS'(1);
      acc_vld      <= 1'b0;
      done         <= 1'b0;
    end else begin
      done    <= 1'b0;
      acc_vld <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.func == FUNC_BINARIZE) begin
              done            <= 1'b1;
              res.result_kind <= KIND_PIXEL;
              res.level       <= (cmd.pixel < PIX_BITS'(chosen_level)) ? PIX_MIN : PIX_MAX;
            end else begin
              acc_vld <= 1'b1;
              acc_idx <= pix_idx;
              if (pix_idx > brightest) begin
                brightest <= pix_idx;
              end
              if (cmd.frame_end) begin
                state <= S_DRAIN;
              end
            end
          end
        end
        // The last pixel's count is written back in this cycle.
        S_DRAIN: begin
          total_n  <= '0;
          total_s  <= '0;
          n1       <= '0;
          s1       <= '0;
          best     <= BIN_BITS'(1);
          best_num <= '0;
          best_den <= DEN_BITS'(1);
          bin_idx  <= '0;
          state    <= (brightest == '0) ? S_EMIT : S_SUM_RD;
        end
        S_SUM_RD: begin
          state <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          total_n <= total_n + N_BITS'(ram_rdata);
          total_s <= total_s + S_BITS'(weighted);
          if (bin_idx == brightest) begin
            bin_idx <= '0;
            state   <= S_SR_RD;
          end else begin
            bin_idx <= bin_idx + 1'b1;
            state   <= S_SUM_RD;
          end
        end
        // Threshold bin_idx+1: move bin bin_idx into the lower class.
        S_SR_RD: begin
          state <= S_SR_ACC;
        end
        S_SR_ACC: begin
          n1    <= n1 + N_BITS'(ram_rdata);
          s1    <= s1 + S_BITS'(weighted);
          state <= S_SR_DIFF;
        end
        S_SR_DIFF: begin
          n2    <= total_n - n1;
          s2    <= total_s - s1;
          state <= S_SR_CHK;
        end
        S_SR_CHK: begin
          op <= OP_SN;
          if ((n1 == '0) || (n2 == '0)) begin
            state <= S_NEXT;
          end else begin
            state <= S_MUL_GO;
          end
        end
        S_MUL_GO: begin
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_stat.done) begin
            state <= S_MUL_GO;
            unique case (op)
              OP_SN: begin
                cross_a <= product[P_BITS-1:0];
                op      <= OP_NS;
              end
              OP_NS: begin
                cross_b <= product[P_BITS-1:0];
                op      <= OP_SQ;
              end
              OP_SQ: begin
                num <= product[NUM_BITS-1:0];
                op  <= OP_NN;
              end
              OP_NN: begin
                den <= product[DEN_BITS-1:0];
                op  <= OP_LHS;
              end
              OP_LHS: begin
                lhs <= product[CMP_BITS-1:0];
                op  <= OP_RHS;
              end
              default: begin
                state <= S_CMP;
              end
            endcase
          end
        end
        // Keep the first threshold with a strictly larger score.
        S_CMP: begin
          if (lhs > product[CMP_BITS-1:0]) begin
            best_num <= num;
            best_den <= den;
            best     <= bin_idx + 1'b1;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if ((bin_idx + 1'b1) == brightest) begin
            state <= S_EMIT;
          end else begin
            bin_idx <= bin_idx + 1'b1;
            state   <= S_SR_RD;
          end
        end
        S_EMIT: begin
          chosen_level    <= best;
          done            <= 1'b1;
          res.result_kind <= KIND_THRESHOLD;
          res.level       <= PIX_BITS'(best);
          clr_last        <= brightest;
          brightest       <= '0;
          bin_idx         <= '0;
          state           <= S_CLR;
        end
        // Zero the bins that the frame may have touched.
        S_CLR: begin
          if (bin_idx == clr_last) begin
            state <= S_IDLE;
          end else begin
            bin_idx <= bin_idx + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A threshold beat only ever follows the emit step.
  a_threshold_from_emit: assert property (@(posedge clk) disable iff (rst)
    (done && (res.result_kind == KIND_THRESHOLD)) |-> $past(state == S_EMIT))
    else $error("threshold beat without a finished search");

  // The accumulate write-back never collides with the clearing sweep.
  a_no_acc_in_clear: assert property (@(posedge clk) disable iff (rst)
    !(acc_vld && (state == S_CLR)))
    else $error("accumulate write during histogram clear");

  // The multiplier is only started when it is idle.
  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_req.go |-> !mul_stat.busy)
    else $error("multiplier restarted while busy");

  // An accepted frame-end accumulate beat makes the block busy next cycle.
  a_frame_end_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.func == FUNC_ACCUMULATE) && cmd.frame_end) |=> busy)
    else $error("frame end did not start the search");

endmodule

[tb/tb.sv]
// Testbench for the Otsu threshold binarizer: random frames and masks checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import otb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  cmd_t cmd = '0;
  res_t res;

  // Commands waiting to be driven and results still owed by the block.
  cmd_t pixel_queue[$];
  res_t owed_results[$];

  // Predictor state: histogram, brightest bin and current threshold.
  int unsigned hist[BINS];
  int unsigned top_bin;
  logic [PIX_BITS-1:0] threshold;

  int mismatches = 0;
  int unsigned beats_sent = 0;
  bit idle_enabled = 1'b1;

  otsu_threshold_binarizer_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .res(res)
  );

  always #2 clk = ~clk;

  // Exact integer Otsu search over thresholds 1 to the brightest bin.
  function automatic logic [PIX_BITS-1:0] otsu_search();
    bit [63:0] tot_n, tot_s, n1, s1, n2, s2;
    bit [255:0] a, b, d, num, den, best_num, best_den;
    int best;
    tot_n = 0;
    tot_s = 0;
    n1 = 0;
    s1 = 0;
    best = 1;
    best_num = 0;
    best_den = 1;
    for (int i = 0; i < BINS; i++) begin
      tot_n += hist[i];
      tot_s += 64'(i) * hist[i];
    end
    for (int t = 1; t <= int'(top_bin) && t < BINS; t++) begin
      n1 += hist[t-1];
      s1 += 64'(t - 1) * hist[t-1];
      n2 = tot_n - n1;
      s2 = tot_s - s1;
      if (n1 != 0 && n2 != 0) begin
        a = 256'(s1) * 256'(n2);
        b = 256'(s2) * 256'(n1);
        d = (a >= b) ? a - b : b - a;
        num = d * d;
        den = 256'(n1) * 256'(n2);
        if (num * best_den > best_num * den) begin
          best_num = num;
          best_den = den;
          best = t;
        end
      end
    end
    return PIX_BITS'(best);
  endfunction

  // Work out the result, if any, of one accepted command beat.
  function automatic void otsu_predict(cmd_t c);
    int unsigned idx;
    res_t r;
    if (c.func == FUNC_BINARIZE) begin
      r.result_kind = KIND_PIXEL;
      r.level = (c.pixel < threshold) ? PIX_MIN : PIX_MAX;
      owed_results = {owed_results, r};
    end else begin
      idx = (int'(c.pixel) < BINS) ? c.pixel : BINS - 1;
      if (hist[idx] < COUNT_MAX) hist[idx]++;
      if (idx > top_bin) top_bin = idx;
      if (c.frame_end) begin
        threshold = otsu_search();
        foreach (hist[i]) hist[i] = 0;
        top_bin = 0;
        r.result_kind = KIND_THRESHOLD;
        r.level = threshold;
        owed_results = {owed_results, r};
      end
    end
  endfunction

  // Driver: predict each accepted beat, then offer the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        otsu_predict(cmd);
        beats_sent++;
      end
      if (start && busy) begin
        // Hold the offered beat until it is taken.
      end else if (pixel_queue.size() > 0 &&
                   !(idle_enabled && $urandom_range(99) < 9)) begin
        cmd <= pixel_queue.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
      idle_enabled <= !(beats_sent > 800 && beats_sent < 1100);
    end
  end

  // Monitor: compare each result beat with the oldest owed result.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result beat: kind %0d level %0d", res.result_kind, res.level);
      end else begin
        res_t want;
        want = owed_results.pop_front();
        if (want.result_kind !== res.result_kind || want.level !== res.level) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected kind %0d level %0d, got kind %0d level %0d",
                     want.result_kind, want.level, res.result_kind, res.level);
        end
      end
    end
  end

  function automatic void queue_cmd(logic f, int unsigned p, logic fe);
    cmd_t c;
    c.func = f;
    c.pixel = PIX_BITS'(p);
    c.frame_end = fe;
    pixel_queue = {pixel_queue, c};
  endfunction

  // One accumulate frame of n pixels no brighter than hi.
  function automatic void queue_frame(int unsigned n, int unsigned hi);
    for (int unsigned i = 0; i < n; i++)
      queue_cmd(FUNC_ACCUMULATE, $urandom_range(hi), i == n - 1);
  endfunction

  initial begin
    int unsigned total;
    int unsigned hi;
    foreach (hist[i]) hist[i] = 0;
    top_bin = 0;
    threshold = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset threshold, ignored frame end, degenerate frames, extremes.
    queue_cmd(FUNC_BINARIZE, 0, 1'b0);
    queue_cmd(FUNC_BINARIZE, 1, 1'b1);
    queue_cmd(FUNC_BINARIZE, 255, 1'b0);
    queue_cmd(FUNC_ACCUMULATE, 0, 1'b1);
    queue_cmd(FUNC_ACCUMULATE, 7, 1'b0);
    queue_cmd(FUNC_ACCUMULATE, 7, 1'b1);
    queue_cmd(FUNC_ACCUMULATE, 0, 1'b0);
    queue_cmd(FUNC_ACCUMULATE, 0, 1'b0);
    queue_cmd(FUNC_ACCUMULATE, 255, 1'b0);
    queue_cmd(FUNC_ACCUMULATE, 255, 1'b0);
    queue_cmd(FUNC_ACCUMULATE, 128, 1'b1);
    for (int unsigned p = 126; p < 131; p++) queue_cmd(FUNC_BINARIZE, p, 1'b0);
    queue_cmd(FUNC_BINARIZE, 0, 1'b0);
    queue_cmd(FUNC_BINARIZE, 255, 1'b1);
    queue_cmd(FUNC_ACCUMULATE, 3, 1'b0);
    queue_cmd(FUNC_ACCUMULATE, 3, 1'b0);
    queue_cmd(FUNC_ACCUMULATE, 10, 1'b1);
    queue_cmd(FUNC_BINARIZE, 9, 1'b0);
    queue_cmd(FUNC_BINARIZE, 4, 1'b0);
    total = pixel_queue.size();

    // Random part: frames mostly with a narrow range, a few spanning all bins,
    // each followed by a burst of binarize beats, with stray beats as noise.
    while (total < 1900) begin
      int unsigned n;
      hi = ($urandom_range(49) == 0) ? 255 : $urandom_range(31, 1);
      n = $urandom_range(40, 2);
      queue_frame(n, hi);
      total += n;
      n = $urandom_range(40, 5);
      for (int unsigned i = 0; i < n; i++)
        queue_cmd(FUNC_BINARIZE, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                          : $urandom_range(hi),
                  $urandom_range(1));
      total += n;
    end
    // Close with a frame no brighter than 255, then a single-pixel frame at the brightest bin.
    queue_frame(12, 255);
    queue_cmd(FUNC_ACCUMULATE, 255, 1'b1);

    while (pixel_queue.size() > 0 || start) @(posedge clk);
    while (owed_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("PASS otsu_threshold_binarizer_unit");
    else
      $display("FAIL otsu_threshold_binarizer_unit");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #(4 * 60000000);
    $display("FAIL otsu_threshold_binarizer_unit");
    $finish;
  end

endmodule
